FILE: hw/rtl/bpfc_pkg.sv
// Package for the buddy page free/coalesce core: widths, constants, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpfc_pkg;
    localparam int PageBits  = 16;
    localparam int NumBins   = 32;
    localparam int PageDepth = 1 << PageBits;
    localparam int LinkBits  = PageBits + 1;
    localparam int OrderBits = 5;
    localparam int CountBits = 17;
    localparam int BinBits   = 5;
    localparam logic [LinkBits-1:0] LinkNil = LinkBits'(PageDepth);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_BUDDY,
        S_CHK_BUDDY,
        S_RD_NEXT,
        S_WR_NEXT,
        S_RD_PREV,
        S_WR_PREV,
        S_BIN_UNLINK,
        S_PUSH,
        S_WR_HEAD,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: hw/rtl/buddy_page_free_coalesce_core.sv
// Top level of the buddy page free/coalesce core: page stores and merge sequencer.
// Depends on bpfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | tdata fields (low bit first)
// s_axis  | in  | page_index[15:0]
// m_axis  | out | block_base[15:0], block_order[20:16], bin_count[37:21], zero pad to 40
// An accepted item gets a buddy read and check; each merge level adds two neighbor
// link read/write pairs through the one page store port, a bin update and the next
// buddy read and check; a merge that reaches order 16 skips the last buddy check.
// Bin heads and counts are flip-flops; free flags reset through a clearing pass over all
// 65536 page entries after reset, during which no item is accepted.
// The output register holds a result until taken; a new item is accepted meanwhile, and
// a finished item waits in its last state while the register is still full.
module buddy_page_free_coalesce_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // page_index
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // block_base, block_order, bin_count
);
    localparam int PB = bpfc_pkg::PageBits;
    localparam int LB = bpfc_pkg::LinkBits;
    localparam int OB = bpfc_pkg::OrderBits;
    localparam int CB = bpfc_pkg::CountBits;
    localparam int BB = bpfc_pkg::BinBits;
    localparam int EB = 1 + OB + LB + LB; // free, order, next, prev

    // page store: one entry per page, single port, registered read
    logic [EB-1:0] mem [bpfc_pkg::PageDepth];
    logic [EB-1:0] r_rdata;
    logic [PB-1:0] mem_addr;
    logic          mem_we;
    logic [EB-1:0] mem_wdata;

    logic [LB-1:0] r_head  [bpfc_pkg::NumBins];
    logic [CB-1:0] r_count [bpfc_pkg::NumBins];

    bpfc_pkg::t_state r_state, n_state;
    logic          r_clr_busy;
    logic [PB-1:0] r_clr_cnt;
    logic [PB-1:0] r_base, r_buddy;
    logic [BB-1:0] r_k;
    logic [LB-1:0] r_nx, r_pv;
    logic [39:0]   r_out;
    logic          r_out_v;

    wire           rd_free  = r_rdata[EB-1];
    wire  [OB-1:0] rd_order = r_rdata[EB-2 -: OB];
    wire  [LB-1:0] rd_next  = r_rdata[2*LB-1 -: LB];
    wire  [LB-1:0] rd_prev  = r_rdata[LB-1:0];
    wire           nx_ok    = !r_nx[LB-1];
    wire           pv_ok    = !r_pv[LB-1];
    wire  [LB-1:0] hd       = r_head[r_k];
    // old head was the base itself: its prev link ends up pointing at itself
    wire           hd_self  = (r_nx == {1'b0, r_base});
    // next merge level allowed: below last bin and bit inside the index
    wire           nxt_lvl_ok = (32'(r_k) + 1 < bpfc_pkg::NumBins - 1) && (32'(r_k) + 1 < PB);
    // output register can take a new result
    wire           out_load = !r_out_v || m_axis_tready;

    assign s_axis_tready = (r_state == bpfc_pkg::S_IDLE) && !r_clr_busy;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpfc_pkg::S_IDLE:
                if (s_axis_tready && s_axis_tvalid) n_state = bpfc_pkg::S_RD_BUDDY;
            bpfc_pkg::S_RD_BUDDY:  n_state = bpfc_pkg::S_CHK_BUDDY;
            bpfc_pkg::S_CHK_BUDDY:
                n_state = (rd_free && rd_order == OB'(r_k)) ?
                    bpfc_pkg::S_RD_NEXT : bpfc_pkg::S_PUSH;
            bpfc_pkg::S_RD_NEXT:   n_state = bpfc_pkg::S_WR_NEXT;
            bpfc_pkg::S_WR_NEXT:   n_state = bpfc_pkg::S_RD_PREV;
            bpfc_pkg::S_RD_PREV:   n_state = bpfc_pkg::S_WR_PREV;
            bpfc_pkg::S_WR_PREV:   n_state = bpfc_pkg::S_BIN_UNLINK;
            bpfc_pkg::S_BIN_UNLINK:
                n_state = nxt_lvl_ok ? bpfc_pkg::S_RD_BUDDY : bpfc_pkg::S_PUSH;
            bpfc_pkg::S_PUSH:      n_state = bpfc_pkg::S_WR_HEAD;
            bpfc_pkg::S_WR_HEAD:   n_state = bpfc_pkg::S_OUT;
            bpfc_pkg::S_OUT:       n_state = out_load ? bpfc_pkg::S_IDLE : bpfc_pkg::S_OUT;
            default:               n_state = bpfc_pkg::S_IDLE;
        endcase
    end

    // page store port control
    always_comb begin
        mem_addr  = r_buddy;
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        if (r_clr_busy) begin
            mem_addr  = r_clr_cnt;
            mem_we    = 1'b1;
            mem_wdata = '0;
        end else begin
            unique case (r_state)
                bpfc_pkg::S_RD_BUDDY: mem_addr = r_buddy;
                bpfc_pkg::S_RD_NEXT:  mem_addr = r_nx[PB-1:0];
                bpfc_pkg::S_WR_NEXT: begin
                    mem_addr  = r_nx[PB-1:0];
                    mem_we    = nx_ok;
                    mem_wdata = {r_rdata[EB-1:LB], r_pv};
                end
                bpfc_pkg::S_RD_PREV:  mem_addr = r_pv[PB-1:0];
                bpfc_pkg::S_WR_PREV: begin
                    mem_addr  = r_pv[PB-1:0];
                    mem_we    = pv_ok;
                    mem_wdata = {r_rdata[EB-1 -: 1+OB], r_nx, r_rdata[LB-1:0]};
                end
                bpfc_pkg::S_PUSH:     mem_addr = hd[PB-1:0];
                bpfc_pkg::S_WR_HEAD: begin
                    mem_addr  = hd[PB-1:0];
                    mem_we    = !hd[LB-1];
                    mem_wdata = {r_rdata[EB-1:LB], {1'b0, r_base}};
                end
                bpfc_pkg::S_OUT: begin
                    mem_addr  = r_base;
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, OB'(r_k), r_nx,
                                 hd_self ? {1'b0, r_base} : bpfc_pkg::LinkNil};
                end
                default: mem_addr = r_buddy;
            endcase
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bpfc_pkg::S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_out_v    <= 1'b0;
            for (int b = 0; b < bpfc_pkg::NumBins; b++) begin
                r_head[b]  <= bpfc_pkg::LinkNil;
                r_count[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == '1) r_clr_busy <= 1'b0;
            end
            // output register
            if (r_state == bpfc_pkg::S_OUT && out_load) begin
                r_out   <= {2'b00, r_count[r_k], OB'(r_k), r_base};
                r_out_v <= 1'b1;
            end else if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                bpfc_pkg::S_IDLE:
                    if (s_axis_tready && s_axis_tvalid) begin
                        r_base  <= s_axis_tdata[PB-1:0];
                        r_buddy <= s_axis_tdata[PB-1:0] ^ PB'(1);
                        r_k     <= '0;
                    end
                bpfc_pkg::S_CHK_BUDDY: begin
                    r_nx <= rd_next;
                    r_pv <= rd_prev;
                end
                bpfc_pkg::S_BIN_UNLINK: begin
                    if (r_head[r_k] == {1'b0, r_buddy}) r_head[r_k] <= r_nx;
                    r_count[r_k] <= r_count[r_k] - 1'b1;
                    if (r_buddy < r_base) begin
                        r_base  <= r_buddy;
                        r_buddy <= r_buddy ^ (PB'(1) << (r_k + 1'b1));
                    end else begin
                        r_buddy <= r_base ^ (PB'(1) << (r_k + 1'b1));
                    end
                    r_k <= r_k + 1'b1;
                end
                bpfc_pkg::S_PUSH: r_nx <= hd;
                bpfc_pkg::S_WR_HEAD: begin
                    r_head[r_k]  <= {1'b0, r_base};
                    r_count[r_k] <= r_count[r_k] + 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
